// ----- rtl/wtofa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtofa_pkg
// Shared widths, register codes, wave and cosine table generation and
// saturation helpers for the wavetable oscillator with folder and allpass.
// ----------------------------------------------------------------------------
package wtofa_pkg;

    localparam int TABLE_DEPTH     = 1024;
    localparam int COS_TABLE_DEPTH = 256;

    localparam int FREQ_W     = 24;
    localparam int SAMPLE_W   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;
    localparam int COEF_W     = 24;
    localparam int SCALE_W    = 28;
    localparam int PHASE_W    = 32;
    localparam int DELAY_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int TURN_W     = 18;

    // shared multiplier operand and product widths
    localparam int MA_W   = 33;
    localparam int MB_W   = 27;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = 64;
    localparam int E_W    = 27;
    localparam int WT_W   = 22;

    localparam logic [SCALE_W-1:0]         SCALE_RESET  = 28'd24988901;
    localparam logic signed [SAMPLE_W-1:0] SQUARE_LEVEL = 24'sd943718;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOLD_GAIN      = 3'd0,
        REG_FOLD_OFFSET    = 3'd1,
        REG_FOLD_ENABLE    = 3'd2,
        REG_ALLPASS_ENABLE = 3'd3,
        REG_ALLPASS_C      = 3'd4,
        REG_ALLPASS_D      = 3'd5,
        REG_WAVE_SELECT    = 3'd6,
        REG_PHASE_SCALE    = 3'd7
    } t_reg_idx;

    // odd harmonic weights 1, -1/9, 1/25, -1/49 in Q20
    function automatic logic signed [WT_W-1:0] harm_weight(input logic [1:0] h);
        logic signed [WT_W-1:0] w;
        case (h)
            2'd0:    w = 22'sd1048576;
            2'd1:    w = -22'sd116508;
            2'd2:    w = 22'sd41943;
            default: w = -22'sd21400;
        endcase
        return w;
    endfunction

    // sin(pi/2 * num4 / 2^lg) in Q20 by a Q30 series, elaboration only
    function automatic logic signed [SAMPLE_W-1:0] sin_at(input int unsigned num4,
                                                         input int unsigned lg);
        logic [63:0] q;
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] s;
        logic [63:0] p;
        int k;
        q = (64'(num4) >> lg) & 64'd3;
        u = (64'(num4) & ((64'd1 << lg) - 64'd1)) << (32 - lg);
        v = q[0] ? ((64'd1 << 32) - u) : u;
        x = (64'd1686629713 * v) >> 32;
        x2 = (x * x) >> 30;
        h = 64'd1073741824;
        for (k = 6; k >= 1; k--) begin
            p = (x2 * h) >> 30;
            case (k)
                6:       h = 64'd1073741824 - (p / 64'd156);
                5:       h = 64'd1073741824 - (p / 64'd110);
                4:       h = 64'd1073741824 - (p / 64'd72);
                3:       h = 64'd1073741824 - (p / 64'd42);
                2:       h = 64'd1073741824 - (p / 64'd20);
                default: h = 64'd1073741824 - (p / 64'd6);
            endcase
        end
        s = (x * h) >> 30;
        s = (s + 64'd512) >> 10;
        if (s > 64'd1048576) begin
            s = 64'd1048576;
        end
        return q[1] ? -$signed(SAMPLE_W'(s)) : $signed(SAMPLE_W'(s));
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 64'sd8388607) begin
            r = 24'sd8388607;
        end else if (v < -64'sd8388608) begin
            r = -24'sd8388608;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DELAY_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DELAY_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[DELAY_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/wtofa_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtofa channel interfaces
// Valid/ready channels for frequency words, sample words and register writes.
// ----------------------------------------------------------------------------
interface wtofa_freq_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [wtofa_pkg::FREQ_W-1:0]        frequency;
    modport source (output valid, output frequency, input ready);
    modport sink   (input valid, input frequency, output ready);
endinterface

interface wtofa_sample_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [wtofa_pkg::SAMPLE_W-1:0]      sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface wtofa_cfg_if;
    logic                                       valid;
    logic                                       ready;
    logic [wtofa_pkg::CFG_IDX_W-1:0]            index;
    logic [wtofa_pkg::CFG_DATA_W-1:0]           data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/wtofa_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtofa_rom
// Wave table read (quarter-wave sine or computed square) and cosine table
// read of two neighbouring entries.
// ----------------------------------------------------------------------------
module wtofa_rom #(
    parameter int TABLE_DEPTH     = wtofa_pkg::TABLE_DEPTH,
    parameter int COS_TABLE_DEPTH = wtofa_pkg::COS_TABLE_DEPTH
) (
    input  logic [$clog2(TABLE_DEPTH)-1:0]          i_wave_addr,
    input  logic                                    i_wave_sel,
    input  logic [$clog2(COS_TABLE_DEPTH)-1:0]      i_cos_idx,
    output logic signed [wtofa_pkg::SAMPLE_W-1:0]   o_wave,
    output logic signed [wtofa_pkg::SAMPLE_W-1:0]   o_cos_a,
    output logic signed [wtofa_pkg::SAMPLE_W-1:0]   o_cos_b
);
    localparam int LD = $clog2(TABLE_DEPTH);
    localparam int LC = $clog2(COS_TABLE_DEPTH);
    localparam int QD = TABLE_DEPTH / 4;

    logic signed [wtofa_pkg::SAMPLE_W-1:0] w_quarter [QD+1];
    logic signed [wtofa_pkg::SAMPLE_W-1:0] w_cos     [COS_TABLE_DEPTH];
    logic [1:0]                            w_quad;
    logic [LD-2:0]                         w_qidx;
    logic signed [wtofa_pkg::SAMPLE_W-1:0] w_sine;
    logic [LC-1:0]                         w_cos_next;

    for (genvar g = 0; g <= QD; g++) begin : g_quarter
        assign w_quarter[g] = wtofa_pkg::sin_at(4 * g, LD);
    end

    for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_cos
        assign w_cos[g] = wtofa_pkg::sin_at(4 * g + COS_TABLE_DEPTH, LC);
    end

    // odd quadrants mirror the quarter wave, the upper half is negated
    assign w_quad = i_wave_addr[LD-1:LD-2];
    assign w_qidx = w_quad[0] ? ((LD-1)'(QD) - {1'b0, i_wave_addr[LD-3:0]})
                              : {1'b0, i_wave_addr[LD-3:0]};
    assign w_sine = w_quad[1] ? -w_quarter[w_qidx] : w_quarter[w_qidx];

    always_comb begin
        if (i_wave_sel) begin
            o_wave = (i_wave_addr <= LD'(TABLE_DEPTH / 2)) ? -wtofa_pkg::SQUARE_LEVEL
                                                             : wtofa_pkg::SQUARE_LEVEL;
        end else begin
            o_wave = w_sine;
        end
    end

    assign w_cos_next = i_cos_idx + LC'(1);
    assign o_cos_a    = w_cos[i_cos_idx];
    assign o_cos_b    = w_cos[w_cos_next];

endmodule

// ----- rtl/wtofa_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtofa_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module wtofa_mul (
    input  logic                                    i_clk,
    input  logic signed [wtofa_pkg::MA_W-1:0]       i_a,
    input  logic signed [wtofa_pkg::MB_W-1:0]       i_b,
    output logic signed [wtofa_pkg::PROD_W-1:0]     o_prod
);
    logic signed [wtofa_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/wavetable_osc_fold_allpass.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_osc_fold_allpass
// Wavetable oscillator with cubic interpolation, optional cosine wavefolder
// and optional second-order allpass, all on one shared multiplier.
// ----------------------------------------------------------------------------
// One frequency word is in work at a time; it runs the multiplier sequence of the
// enabled stages, and the next word waits until its sample is in the output register.
// A new word is taken while the previous sample waits at the output.
// Synchronous active-low reset clears phase and filter delays and returns the
// registers to their reset values; the wave and cosine tables are constant and need no fill after reset.
module wavetable_osc_fold_allpass #(
    parameter int TABLE_DEPTH     = wtofa_pkg::TABLE_DEPTH,
    parameter int COS_TABLE_DEPTH = wtofa_pkg::COS_TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    wtofa_freq_if.sink            i_freq,
    wtofa_sample_if.source        o_sample,
    wtofa_cfg_if.sink             i_cfg
);
    localparam int LD = $clog2(TABLE_DEPTH);
    localparam int LC = $clog2(COS_TABLE_DEPTH);
    localparam int SW = wtofa_pkg::SAMPLE_W;
    localparam int AW = wtofa_pkg::ACC_W;
    localparam int MA = wtofa_pkg::MA_W;
    localparam int MB = wtofa_pkg::MB_W;
    localparam int TW = wtofa_pkg::TURN_W;

    typedef enum logic [25:0] {
        S_IDLE  = 26'd1 << 0,
        S_STEP  = 26'd1 << 1,
        S_PHASE = 26'd1 << 2,
        S_FETCH = 26'd1 << 3,
        S_INT0  = 26'd1 << 4,
        S_MUL1  = 26'd1 << 5,
        S_INT1  = 26'd1 << 6,
        S_MUL2  = 26'd1 << 7,
        S_INT2  = 26'd1 << 8,
        S_MUL3  = 26'd1 << 9,
        S_INT3  = 26'd1 << 10,
        S_FGAIN = 26'd1 << 11,
        S_FING  = 26'd1 << 12,
        S_HLOOK = 26'd1 << 13,
        S_HDIFF = 26'd1 << 14,
        S_HSUM  = 26'd1 << 15,
        S_HWT   = 26'd1 << 16,
        S_FEND  = 26'd1 << 17,
        S_AP0   = 26'd1 << 18,
        S_AP1   = 26'd1 << 19,
        S_AP2   = 26'd1 << 20,
        S_AP3   = 26'd1 << 21,
        S_AP4   = 26'd1 << 22,
        S_AP5   = 26'd1 << 23,
        S_AP6   = 26'd1 << 24,
        S_DONE  = 26'd1 << 25
    } t_state;

    t_state r_state, n_state;

    // registers
    logic signed [SW-1:0]                      r_gain, r_offset, r_c, r_d;
    logic                                      r_fold_en, r_ap_en, r_wave;
    logic [wtofa_pkg::SCALE_W-1:0]             r_scale;

    // control and state
    logic [wtofa_pkg::PHASE_W-1:0]             r_phase;
    logic [1:0]                                r_cnt;
    logic signed [wtofa_pkg::DELAY_W-1:0]      r_x1, r_x2, r_y1, r_y2;
    logic                                      r_out_valid;

    // payload
    logic signed [wtofa_pkg::FREQ_W-1:0]       r_freq;
    logic signed [SW-1:0]                      r_m1, r_c0, r_p1, r_p2;
    logic signed [MA-1:0]                      r_t;
    logic signed [SW-1:0]                      r_val;
    logic [TW-1:0]                             r_ing;
    logic signed [SW-1:0]                      r_a;
    logic signed [SW:0]                        r_diff;
    logic [TW-1:0]                             r_cf;
    logic signed [AW-1:0]                      r_acc;
    logic signed [wtofa_pkg::E_W-1:0]          r_e;
    logic signed [SW-1:0]                      r_out;

    logic signed [MA-1:0]                      w_ma;
    logic signed [MB-1:0]                      w_mb;
    logic signed [wtofa_pkg::PROD_W-1:0]       w_prod;
    logic [LD-1:0]                             w_idx, w_addr;
    logic [wtofa_pkg::FRAC_W-1:0]              w_fr;
    logic signed [SW-1:0]                      w_wave, w_cos_a, w_cos_b;
    logic [TW-1:0]                             w_turn;
    logic [LC-1:0]                             w_cos_idx;
    logic signed [MA-1:0]                      w_m1, w_c0, w_p1, w_p2;
    logic signed [AW-1:0]                      w_fsum;
    logic signed [wtofa_pkg::PROD_W-1:0]       w_ing;
    logic signed [wtofa_pkg::DELAY_W-1:0]      w_y;
    logic                                      w_accept, w_out_load;

    wtofa_rom #(
        .TABLE_DEPTH     (TABLE_DEPTH),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_rom (
        .i_wave_addr (w_addr),
        .i_wave_sel  (r_wave),
        .i_cos_idx   (w_cos_idx),
        .o_wave      (w_wave),
        .o_cos_a     (w_cos_a),
        .o_cos_b     (w_cos_b)
    );

    wtofa_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    assign i_freq.ready    = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_sample.valid  = r_out_valid;
    assign o_sample.sample = r_out;

    assign w_accept   = i_freq.valid && (r_state == S_IDLE);
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || o_sample.ready);

    assign w_idx  = r_phase[wtofa_pkg::PHASE_W-1 -: LD];
    assign w_fr   = r_phase[wtofa_pkg::PHASE_W-1-LD -: wtofa_pkg::FRAC_W];
    assign w_addr = w_idx + LD'(r_cnt) - LD'(1);

    // harmonic k = 2*cnt+1, only the low turn bits matter
    assign w_turn    = r_ing * TW'({r_cnt, 1'b1});
    assign w_cos_idx = w_turn[TW-1 -: LC];

    assign w_m1 = MA'(r_m1);
    assign w_c0 = MA'(r_c0);
    assign w_p1 = MA'(r_p1);
    assign w_p2 = MA'(r_p2);

    assign w_fsum = r_acc + AW'(w_prod);
    assign w_ing  = ((w_prod + 60'sd524288) >>> 20) + 60'(r_offset);
    assign w_y    = wtofa_pkg::sat32((r_acc + 64'sd2097152) >>> 22);

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_STEP: begin
                w_ma = $signed(MA'(r_scale));
                w_mb = MB'(r_freq);
            end
            S_MUL1, S_MUL2, S_MUL3: begin
                w_ma = r_t;
                w_mb = $signed(MB'(w_fr));
            end
            S_FGAIN: begin
                w_ma = MA'(r_val);
                w_mb = MB'(r_gain);
            end
            S_HDIFF: begin
                w_ma = MA'(r_diff);
                w_mb = $signed(MB'(r_cf));
            end
            S_HWT: begin
                w_ma = r_t;
                w_mb = MB'(wtofa_pkg::harm_weight(r_cnt));
            end
            S_AP0: begin
                w_ma = MA'(r_d);
                w_mb = MB'(r_c);
            end
            S_AP1: begin
                w_ma = MA'(r_val);
                w_mb = MB'(r_c);
            end
            S_AP2: begin
                w_ma = MA'(r_y2);
                w_mb = MB'(r_c);
            end
            S_AP3: begin
                w_ma = MA'(r_x1);
                w_mb = r_e;
            end
            S_AP4: begin
                w_ma = MA'(r_y1);
                w_mb = r_e;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_STEP;
            S_STEP:  n_state = S_PHASE;
            S_PHASE: n_state = S_FETCH;
            S_FETCH: if (r_cnt == 2'd3) n_state = S_INT0;
            S_INT0:  n_state = S_MUL1;
            S_MUL1:  n_state = S_INT1;
            S_INT1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_INT2;
            S_INT2:  n_state = S_MUL3;
            S_MUL3:  n_state = S_INT3;
            S_INT3: begin
                if (r_fold_en) n_state = S_FGAIN;
                else if (r_ap_en) n_state = S_AP0;
                else n_state = S_DONE;
            end
            S_FGAIN: n_state = S_FING;
            S_FING:  n_state = S_HLOOK;
            S_HLOOK: n_state = S_HDIFF;
            S_HDIFF: n_state = S_HSUM;
            S_HSUM:  n_state = S_HWT;
            S_HWT:   n_state = (r_cnt == 2'd3) ? S_FEND : S_HLOOK;
            S_FEND:  n_state = r_ap_en ? S_AP0 : S_DONE;
            S_AP0:   n_state = S_AP1;
            S_AP1:   n_state = S_AP2;
            S_AP2:   n_state = S_AP3;
            S_AP3:   n_state = S_AP4;
            S_AP4:   n_state = S_AP5;
            S_AP5:   n_state = S_AP6;
            S_AP6:   n_state = S_DONE;
            S_DONE:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control, registers and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain      <= '0;
            r_offset    <= '0;
            r_fold_en   <= 1'b0;
            r_ap_en     <= 1'b0;
            r_c         <= '0;
            r_d         <= '0;
            r_wave      <= 1'b0;
            r_scale     <= wtofa_pkg::SCALE_RESET;
            r_phase     <= '0;
            r_cnt       <= '0;
            r_x1        <= '0;
            r_x2        <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                unique case (wtofa_pkg::t_reg_idx'(i_cfg.index))
                    wtofa_pkg::REG_FOLD_GAIN:      r_gain    <= SW'(i_cfg.data);
                    wtofa_pkg::REG_FOLD_OFFSET:    r_offset  <= SW'(i_cfg.data);
                    wtofa_pkg::REG_FOLD_ENABLE:    r_fold_en <= i_cfg.data[0];
                    wtofa_pkg::REG_ALLPASS_ENABLE: r_ap_en   <= i_cfg.data[0];
                    wtofa_pkg::REG_ALLPASS_C:      r_c       <= SW'(i_cfg.data);
                    wtofa_pkg::REG_ALLPASS_D:      r_d       <= SW'(i_cfg.data);
                    wtofa_pkg::REG_WAVE_SELECT:    r_wave    <= i_cfg.data[0];
                    wtofa_pkg::REG_PHASE_SCALE:    r_scale   <= i_cfg.data;
                    default: ;
                endcase
            end

            case (r_state)
                S_PHASE: begin
                    r_phase <= r_phase + w_prod[47:16];
                    r_cnt   <= '0;
                end
                S_FETCH, S_HWT: r_cnt <= r_cnt + 2'd1;
                S_FING:  r_cnt <= '0;
                S_AP6: begin
                    r_x2 <= r_x1;
                    r_x1 <= wtofa_pkg::DELAY_W'(r_val);
                    r_y2 <= r_y1;
                    r_y1 <= w_y;
                end
                default: ;
            endcase

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_sample.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath words
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_freq <= i_freq.frequency;
        end
        if (w_out_load) begin
            r_out <= r_val;
        end
        case (r_state)
            S_FETCH: begin
                case (r_cnt)
                    2'd0:    r_m1 <= w_wave;
                    2'd1:    r_c0 <= w_wave;
                    2'd2:    r_p1 <= w_wave;
                    default: r_p2 <= w_wave;
                endcase
            end
            S_INT0: r_t <= 33'sd3 * (w_c0 - w_p1) - w_m1 + w_p2;
            S_INT1: r_t <= 33'sd4 * w_p1 + 33'sd2 * w_m1 - 33'sd5 * w_c0 - w_p2
                           + MA'(w_prod >>> 16);
            S_INT2: r_t <= w_p1 - w_m1 + MA'(w_prod >>> 16);
            S_INT3: r_val <= wtofa_pkg::sat24(AW'(r_c0) + AW'(w_prod >>> 17));
            S_FING: begin
                r_ing <= w_ing[TW-1:0];
                r_acc <= '0;
            end
            S_HLOOK: begin
                // previous harmonic's weighted term is still in the product register
                if (r_cnt != 2'd0) begin
                    r_acc <= w_fsum;
                end
                r_a    <= w_cos_a;
                r_diff <= (SW+1)'(w_cos_b) - (SW+1)'(w_cos_a);
                r_cf   <= {w_turn[TW-1-LC:0], {LC{1'b0}}};
            end
            S_HSUM: r_t <= MA'(r_a) + MA'(w_prod >>> 18);
            S_FEND: r_val <= wtofa_pkg::sat24((w_fsum + 64'sd524288) >>> 20);
            S_AP1: begin
                r_e   <= wtofa_pkg::E_W'(r_d)
                         - wtofa_pkg::E_W'((w_prod + 60'sd2097152) >>> 22);
                r_acc <= AW'(r_x2) <<< 22;
            end
            S_AP2: r_acc <= r_acc - AW'(w_prod);
            S_AP3, S_AP4: r_acc <= w_fsum;
            S_AP5: r_acc <= r_acc - AW'(w_prod);
            S_AP6: r_val <= wtofa_pkg::sat24(AW'(w_y));
            default: ;
        endcase
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable oscillator testbench
// Drives frequency words and register writes into the oscillator, predicts
// every sample word from its own fixed-point model of the phase, cubic
// wavetable read, cosine folder and allpass, and compares in order.
// ----------------------------------------------------------------------------
module testbench;
    import wtofa_pkg::*;

    localparam int  WAVE_N   = 1024;
    localparam int  COS_N    = 256;
    localparam longint LIMIT = 1500000;

    class osc_scoreboard;
        longint         gain, offset, c, d;
        bit             fold_on, ap_on, square_sel;
        longint         step_scale;
        logic [31:0]    phase;
        longint         x1, x2, y1, y2;
        longint         wave[2][WAVE_N];
        longint         cosv[COS_N];
        logic signed [SAMPLE_W-1:0] pending[$];
        int             errors;

        function new();
            gain = 0; offset = 0; c = 0; d = 0;
            fold_on = 0; ap_on = 0; square_sel = 0;
            step_scale = SCALE_RESET;
            phase = 0; x1 = 0; x2 = 0; y1 = 0; y2 = 0;
            errors = 0;
            for (int i = 0; i < WAVE_N; i++) begin
                wave[0][i] = series_sine(4 * i, WAVE_N);
                wave[1][i] = (i <= WAVE_N / 2) ? -943718 : 943718;
            end
            for (int i = 0; i < COS_N; i++) begin
                cosv[i] = series_sine(4 * i + COS_N, COS_N);
            end
        endfunction

        // sin(pi/2 * num4/den) in Q20 through a Q30 odd series
        function longint series_sine(int unsigned num4, int unsigned den);
            longint unsigned q, u, v, x, xx, h, s;
            q = (num4 / den) & 3;
            u = (longint'(num4 % den) << 32) / den;
            v = q[0] ? ((64'd1 << 32) - u) : u;
            x = (64'd1686629713 * v) >> 32;
            xx = (x * x) >> 30;
            h = 64'd1073741824;
            for (int k = 6; k >= 1; k--) begin
                h = 64'd1073741824 - ((xx * h) >> 30) / longint'((2 * k) * (2 * k + 1));
            end
            s = (x * h) >> 30;
            s = (s + 512) >> 10;
            if (s > 1048576) begin
                s = 1048576;
            end
            return q[1] ? -longint'(s) : longint'(s);
        endfunction

        function longint clip(longint v, int w);
            longint hi, lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function longint round_shift(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function longint cos_at(longint turns);
            logic [63:0] t;
            longint p, a, b, cf;
            int ci;
            t = turns;
            p = longint'(t[17:0]) * COS_N;
            ci = (p >> 18) % COS_N;
            cf = p & 64'h3FFFF;
            a = cosv[ci];
            b = cosv[(ci + 1) % COS_N];
            return a + (((b - a) * cf) >>> 18);
        endfunction

        function void write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_FOLD_GAIN:      gain = longint'($signed(v[23:0]));
                REG_FOLD_OFFSET:    offset = longint'($signed(v[23:0]));
                REG_FOLD_ENABLE:    fold_on = v[0];
                REG_ALLPASS_ENABLE: ap_on = v[0];
                REG_ALLPASS_C:      c = longint'($signed(v[23:0]));
                REG_ALLPASS_D:      d = longint'($signed(v[23:0]));
                REG_WAVE_SELECT:    square_sel = v[0];
                default:            step_scale = longint'(v);
            endcase
        endfunction

        function void note_frequency(logic signed [FREQ_W-1:0] f);
            logic [63:0] prod;
            logic [9:0]  idx;
            longint fr, m1, c0, p1, p2, t, val, ing, acc, e, y;
            prod = longint'(f) * step_scale;
            phase = phase + prod[47:16];
            idx = phase[31:22];
            fr = longint'(phase[21:6]);
            m1 = wave[square_sel][10'(idx - 1)];
            c0 = wave[square_sel][idx];
            p1 = wave[square_sel][10'(idx + 1)];
            p2 = wave[square_sel][10'(idx + 2)];
            t = 3 * (c0 - p1) - m1 + p2;
            t = 4 * p1 + 2 * m1 - 5 * c0 - p2 + ((fr * t) >>> 16);
            t = p1 - m1 + ((fr * t) >>> 16);
            val = clip(c0 + ((fr * t) >>> 17), 24);
            if (fold_on) begin
                ing = round_shift(gain * val, 20) + offset;
                acc = cos_at(ing) * 1048576 - 116508 * cos_at(3 * ing)
                    + 41943 * cos_at(5 * ing) - 21400 * cos_at(7 * ing);
                val = clip(round_shift(acc, 20), 24);
            end
            if (ap_on) begin
                e = d - round_shift(d * c, 22);
                acc = -c * val + e * x1 + x2 * 4194304 - e * y1 + c * y2;
                y = clip(round_shift(acc, 22), 32);
                x2 = x1; x1 = val; y2 = y1; y1 = y;
                val = y;
            end
            pending.push_back(SAMPLE_W'(clip(val, 24)));
        endfunction

        function void check_sample(logic signed [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected sample word, expected none, actual %0d", $time, got);
                errors++;
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    $display("%0t: sample expected %0d, actual %0d", $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    always #4 i_clk = ~i_clk;

    wtofa_freq_if   freq_ch();
    wtofa_sample_if sample_ch();
    wtofa_cfg_if    cfg_ch();

    wavetable_osc_fold_allpass i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_freq   (freq_ch),
        .o_sample (sample_ch),
        .i_cfg    (cfg_ch)
    );

    osc_scoreboard sb = new();
    int     send_idle_pct = 0;
    int     sink_stall_pct = 0;
    int     hold_off = 0;
    longint cycles = 0;

    initial begin
        freq_ch.valid = 0;
        freq_ch.frequency = 0;
        sample_ch.ready = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = REG_FOLD_GAIN;
        cfg_ch.data = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver side; a long hold-off lets the block back up into its input
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            sample_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            sample_ch.ready <= i_rst_n && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && sample_ch.valid && sample_ch.ready) begin
            sb.check_sample(sample_ch.sample);
        end
    end

    task automatic send_frequency(logic signed [FREQ_W-1:0] f);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            freq_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        freq_ch.valid <= 1'b1;
        freq_ch.frequency <= f;
        do @(posedge i_clk); while (!freq_ch.ready);
        sb.note_frequency(f);
    endtask

    task automatic write_reg(t_reg_idx idx, longint v);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= CFG_DATA_W'(v);
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, CFG_DATA_W'(v));
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        freq_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic set_all(longint g, longint o, bit fe, bit ae, longint cc, longint dd,
                           bit ws, longint sc);
        write_reg(REG_FOLD_GAIN, g);
        write_reg(REG_FOLD_OFFSET, o);
        write_reg(REG_FOLD_ENABLE, fe);
        write_reg(REG_ALLPASS_ENABLE, ae);
        write_reg(REG_ALLPASS_C, cc);
        write_reg(REG_ALLPASS_D, dd);
        write_reg(REG_WAVE_SELECT, ws);
        write_reg(REG_PHASE_SCALE, sc);
    endtask

    function automatic logic signed [FREQ_W-1:0] random_frequency();
        logic signed [FREQ_W-1:0] f;
        if ($urandom_range(1)) begin
            f = FREQ_W'($urandom);
        end else begin
            f = FREQ_W'($urandom_range(600000));
            if ($urandom_range(3) == 0) f = -f;
        end
        return f;
    endfunction

    function automatic longint rand24();
        return longint'($signed(24'($urandom)));
    endfunction

    initial begin
        logic signed [FREQ_W-1:0] directed[$];
        directed = '{24'sd0, 24'sd8388607, -24'sd8388608, -24'sd1, 24'sd1, 24'sd112640,
                     -24'sd112640, 24'sd8388607, 24'sd8388607, -24'sd8388608, 24'sd0,
                     24'sd256, 24'sd4096000, -24'sd4096000, 24'sd5592405, -24'sd5592406};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // defaults first, then wrap, extremes and table switching in the directed part
        foreach (directed[k]) send_frequency(directed[k]);
        drain();
        set_all(65536, 0, 1, 1, 4194303, -4194304, 1, 268435455);
        foreach (directed[k]) if (k < 6) send_frequency(directed[k]);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_all(rand24(), rand24(), 0, 0, 0, 0, 0, 24988901);
                1: set_all(rand24() >>> 4, rand24() >>> 6, 1, 0, 0, 0, 1, 24988901);
                2: set_all(0, 0, 0, 1, rand24() >>> 2, rand24() >>> 2, 0, $urandom_range(40000000));
                3: set_all(8388607, -8388608, 1, 1, -8388608, 8388607, 1, 268435455);
                4: set_all(-8388608, 8388607, 1, 1, 8388607, -8388608, 0, 0);
                default: set_all(rand24(), rand24(), $urandom_range(1), $urandom_range(1),
                                 rand24(), rand24(), $urandom_range(1),
                                 $urandom_range(1) ? $urandom_range(268435455)
                                                   : $urandom_range(50000000));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 58; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 58; end
                default: begin send_idle_pct = 6; sink_stall_pct = 6; end
            endcase
            if (ph == 4) hold_off = 400;
            for (int n = 0; n < 130; n++) begin
                send_frequency(random_frequency());
                // a stretch with no idling inside some phases
                if (n == 100 && ph % 4 != 0) begin
                    send_idle_pct = 0;
                    sink_stall_pct = 0;
                end
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
